@@ rtl/core/nv21_to_planar_half_scale_core_defines.svh @@
// assertion macros for the checker file nv21hs_chk
`ifndef NV21_TO_PLANAR_HALF_SCALE_CORE_DEFINES_SVH
`define NV21_TO_PLANAR_HALF_SCALE_CORE_DEFINES_SVH

// property holds at every clock edge outside reset
`define NV21HS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold on the clock edge after the antecedent
`define NV21HS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nv21hs_pkg.sv @@
package nv21hs_pkg;

    localparam int PIX_W      = 8;
    localparam int PLANE_W    = 2;
    localparam int OUT_COL_W  = 11;
    localparam int OUT_ROW_W  = 11;
    localparam int SAMPLE_W   = 8;
    localparam int PAIR_W     = 9;
    localparam int CFG_REG_W  = 12;
    localparam int CFG_IDX_W  = 1;

    localparam int MAX_OUT_WIDTH_DEF = 2048;
    localparam int MAX_OUT_HEIGHT    = 2048;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

    localparam logic [CFG_REG_W-1:0] OUT_WIDTH_RST  = 12'd176;
    localparam logic [CFG_REG_W-1:0] OUT_HEIGHT_RST = 12'd144;

    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // one sample in flight: position, pair sum of the odd row, frame end flag
    typedef struct packed {
        logic [PLANE_W-1:0]   plane;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [PAIR_W-1:0]    pair;
        logic                 done;
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PAIR_W-1:0] line_sum;
    } entry_t;

endpackage

@@ rtl/core/nv21hs_if.sv @@
interface nv21hs_pix_if
    import nv21hs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

interface nv21hs_smp_if
    import nv21hs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PLANE_W-1:0]   plane;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [SAMPLE_W-1:0]  sample_value;
    logic                 frame_done;

    modport source (output valid, output plane, output out_col, output out_row,
                    output sample_value, output frame_done, input ready);
    modport sink (input valid, input plane, input out_col, input out_row,
                  input sample_value, input frame_done, output ready);
endinterface

@@ rtl/core/nv21_to_planar_half_scale_core.sv @@
// nv21 to planar 2x2 box downscaler
//
// src takes one source byte per request: the luma plane of 2*out_width by
// 2*out_height bytes in raster order, then out_height rows of interleaved
// v,u bytes. dst gives one output sample per finished 2x2 block with its
// plane (0 luma, 1 u, 2 v), column, row and the truncated mean; frame_done
// marks the last u sample of the frame. even source rows produce nothing.
// cfg_we/cfg_index/cfg_data write out_width (index 0) and out_height
// (index 1); the user must write them only while the block is idle, which
// the block does not enforce. values above the maxima are clamped.
// throughput is one byte per cycle while the queue has room. a completed
// sample passes the line store read, the queue and the output register.
// reset returns to luma row 0, column 0 with widths 176 by 144; the line
// store is not cleared and needs no clearing pass.
// when dst stalls the output register holds its sample and the 4-entry
// queue fills; src.ready drops once the queue has no room left.
module nv21_to_planar_half_scale_core
    import nv21hs_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    nv21hs_pix_if.sink           src,
    nv21hs_smp_if.source         dst,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_REG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_OUT_WIDTH);

    logic [CFG_REG_W-1:0] out_width_reg;
    logic [CFG_REG_W-1:0] out_height_reg;
    logic                 accept;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [PAIR_W-1:0]    ram_wdata;
    logic [PAIR_W-1:0]    ram_rdata;
    logic                 op_valid;
    op_t                  op;
    logic                 pop;
    logic                 head_valid;
    entry_t               head;
    logic                 room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                CFG_OUT_HEIGHT: out_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign src.ready = room;
    assign accept    = src.valid && room;

    nv21hs_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel_byte (src.pixel_byte),
        .out_width  (out_width_reg),
        .out_height (out_height_reg),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .op_valid   (op_valid),
        .op         (op)
    );

    nv21hs_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    nv21hs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (op),
        .line_sum   (ram_rdata),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .room       (room)
    );

    nv21hs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dst        (dst)
    );

endmodule

@@ rtl/core/nv21hs_ram.sv @@
module nv21hs_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

@@ rtl/core/nv21hs_front.sv @@
module nv21hs_front
    import nv21hs_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [PIX_W-1:0]                     pixel_byte,
    input  logic [CFG_REG_W-1:0]                 out_width,
    input  logic [CFG_REG_W-1:0]                 out_height,
    output logic                                 ram_we,
    output logic [$clog2(MAX_OUT_WIDTH)-1:0]     ram_addr,
    output logic [PAIR_W-1:0]                    ram_wdata,
    output logic                                 op_valid,
    output op_t                                  op
);

    localparam int AW = $clog2(MAX_OUT_WIDTH);
    localparam int WW = $clog2(MAX_OUT_WIDTH + 1);
    localparam int CW = WW + 1;
    localparam int HW = CFG_REG_W;

    localparam logic [1:0] POS_V  = 2'd0;
    localparam logic [1:0] POS_U  = 2'd1;
    localparam logic [1:0] POS_VP = 2'd2;

    logic [CW-1:0]    sc_reg, sc_next;
    logic [HW-1:0]    sr_reg, sr_next;
    logic             chroma_reg, chroma_next;
    logic [PIX_W-1:0] held_y_reg, held_y_next;
    logic [PIX_W-1:0] held_v_reg, held_v_next;
    logic [PIX_W-1:0] held_u_reg, held_u_next;

    logic [WW-1:0]        w;
    logic [HW-1:0]        h;
    logic [CW-1:0]        two_w;
    logic [HW:0]          plane_rows;
    logic [CW:0]          sc_inc;
    logic [HW:0]          sr_inc;
    logic [1:0]           pos;
    logic [WW-2:0]        grp;
    logic [OUT_ROW_W-1:0] row;
    logic [WW-1:0]        idx;
    logic [PAIR_W-1:0]    pair;
    logic                 is_pair;
    logic                 last_block;

    assign w = (32'(out_width) > 32'(MAX_OUT_WIDTH)) ? WW'(MAX_OUT_WIDTH) : WW'(out_width);
    assign h = (out_height > HW'(MAX_OUT_HEIGHT)) ? HW'(MAX_OUT_HEIGHT) : out_height;
    assign two_w = {w, 1'b0};
    assign pos = sc_reg[1:0];
    assign grp = sc_reg[CW-1:2];
    assign row = sr_reg[HW-1:1];
    assign sc_inc = {1'b0, sc_reg} + (CW+1)'(1);
    assign sr_inc = {1'b0, sr_reg} + (HW+1)'(1);

    assign last_block = (h >= HW'(2)) && (w >= WW'(2))
                     && ({1'b0, row} == (h >> 1) - HW'(1))
                     && ({1'b0, grp} == (w >> 1) - WW'(1));

    always_comb
    begin
        held_y_next = held_y_reg;
        held_v_next = held_v_reg;
        held_u_next = held_u_reg;
        is_pair     = 1'b0;
        pair        = '0;
        op.plane    = PLANE_Y;
        op.done     = 1'b0;
        if (!chroma_reg)
        begin
            plane_rows = {h, 1'b0};
            idx        = sc_reg[CW-1:1];
            op.col     = OUT_COL_W'(sc_reg[CW-1:1]);
            if (!sc_reg[0])
            begin
                held_y_next = accept ? pixel_byte : held_y_reg;
            end
            else
            begin
                is_pair = 1'b1;
                pair    = {1'b0, held_y_reg} + {1'b0, pixel_byte};
            end
        end
        else
        begin
            plane_rows = {1'b0, h};
            idx        = {sc_reg[CW-1:2], sc_reg[0]};
            op.col     = OUT_COL_W'(grp);
            case (pos)
                POS_V:
                begin
                    held_v_next = accept ? pixel_byte : held_v_reg;
                end
                POS_U:
                begin
                    held_u_next = accept ? pixel_byte : held_u_reg;
                end
                POS_VP:
                begin
                    is_pair  = 1'b1;
                    pair     = {1'b0, held_v_reg} + {1'b0, pixel_byte};
                    op.plane = PLANE_V;
                end
                default:
                begin
                    is_pair  = 1'b1;
                    pair     = {1'b0, held_u_reg} + {1'b0, pixel_byte};
                    op.plane = PLANE_U;
                    op.done  = last_block;
                end
            endcase
        end
        op.row  = row;
        op.pair = pair;

        sc_next     = sc_reg;
        sr_next     = sr_reg;
        chroma_next = chroma_reg;
        if (accept)
        begin
            if (sc_inc >= {1'b0, two_w})
            begin
                sc_next = '0;
                if (sr_inc >= plane_rows)
                begin
                    sr_next     = '0;
                    chroma_next = !chroma_reg;
                end
                else
                begin
                    sr_next = sr_inc[HW-1:0];
                end
            end
            else
            begin
                sc_next = sc_inc[CW-1:0];
            end
        end
    end

    // even source rows store pair sums, odd rows fetch them to finish a block
    assign ram_we    = accept && is_pair && !sr_reg[0];
    assign op_valid  = accept && is_pair && sr_reg[0];
    assign ram_addr  = idx[AW-1:0];
    assign ram_wdata = pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg     <= '0;
            sr_reg     <= '0;
            chroma_reg <= 1'b0;
            held_y_reg <= '0;
            held_v_reg <= '0;
            held_u_reg <= '0;
        end
        else
        begin
            sc_reg     <= sc_next;
            sr_reg     <= sr_next;
            chroma_reg <= chroma_next;
            held_y_reg <= held_y_next;
            held_v_reg <= held_v_next;
            held_u_reg <= held_u_next;
        end
    end

endmodule

@@ rtl/core/nv21hs_queue.sv @@
module nv21hs_queue
    import nv21hs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  op_t               op,
    input  logic [PAIR_W-1:0] line_sum,
    input  logic              pop,
    output logic              head_valid,
    output entry_t            head,
    output logic              room
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    entry_t          fifo_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            stage_valid_reg;
    op_t             stage_op_reg;
    logic            push;
    logic [CNTW:0]   occupancy;

    // the stage register delays the op so that it is pushed with the line store read data
    assign push       = stage_valid_reg;
    assign occupancy  = {1'b0, count_reg} + (CNTW+1)'(stage_valid_reg);
    assign room       = occupancy < (CNTW+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
            stage_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            stage_op_reg <= op;
        end
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{op: stage_op_reg, line_sum: line_sum};
        end
    end

endmodule

@@ rtl/core/nv21hs_back.sv @@
module nv21hs_back
    import nv21hs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  entry_t              head,
    output logic                pop,
    nv21hs_smp_if.source        dst
);

    logic                 out_valid_reg;
    logic [PLANE_W-1:0]   plane_reg;
    logic [OUT_COL_W-1:0] col_reg;
    logic [OUT_ROW_W-1:0] row_reg;
    logic [SAMPLE_W-1:0]  value_reg;
    logic                 done_reg;
    logic [PAIR_W:0]      sum4;

    assign sum4 = {1'b0, head.line_sum} + {1'b0, head.op.pair};
    assign pop  = head_valid && (!out_valid_reg || dst.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || dst.ready)
        begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            plane_reg <= head.op.plane;
            col_reg   <= head.op.col;
            row_reg   <= head.op.row;
            value_reg <= sum4[PAIR_W:2];
            done_reg  <= head.op.done;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.plane        = plane_reg;
    assign dst.out_col      = col_reg;
    assign dst.out_row      = row_reg;
    assign dst.sample_value = value_reg;
    assign dst.frame_done   = done_reg;

endmodule

@@ rtl/core/nv21hs_chk.sv @@
`include "nv21_to_planar_half_scale_core_defines.svh"

module nv21hs_chk
    import nv21hs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 src_valid,
    input logic                 src_ready,
    input logic                 dst_valid,
    input logic                 dst_ready,
    input logic [PLANE_W-1:0]   dst_plane,
    input logic [OUT_COL_W-1:0] dst_out_col,
    input logic [OUT_ROW_W-1:0] dst_out_row,
    input logic [SAMPLE_W-1:0]  dst_sample_value,
    input logic                 dst_frame_done
);

    `NV21HS_ASSERT_NEXT(a_dst_hold, clk, rst_n, dst_valid && !dst_ready,
        dst_valid && $stable({dst_plane, dst_out_col, dst_out_row, dst_sample_value,
        dst_frame_done}), "stalled sample changed")

    `NV21HS_ASSERT(a_plane_legal, clk, rst_n,
        !dst_valid || dst_plane == PLANE_Y || dst_plane == PLANE_U || dst_plane == PLANE_V,
        "illegal plane code")

    `NV21HS_ASSERT(a_done_on_u, clk, rst_n,
        !(dst_valid && dst_frame_done) || dst_plane == PLANE_U,
        "frame end flagged on a non u sample")

    `NV21HS_ASSERT(a_rise_after_request, clk, rst_n,
        !$rose(dst_valid) || $past(src_valid && src_ready, 3),
        "sample without a source request three cycles earlier")

endmodule

bind nv21_to_planar_half_scale_core nv21hs_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .src_valid        (src.valid),
    .src_ready        (src.ready),
    .dst_valid        (dst.valid),
    .dst_ready        (dst.ready),
    .dst_plane        (dst.plane),
    .dst_out_col      (dst.out_col),
    .dst_out_row      (dst.out_row),
    .dst_sample_value (dst.sample_value),
    .dst_frame_done   (dst.frame_done)
);
